[hw/rtl/pgb_pkg.sv]
// pgb_pkg: shared types and constants for the palette gradient blender.
// Used by pgb_ctrl, pgb_dp and palette_gradient_blend_core.
package pgb_pkg;

    localparam logic [7:0] INTENSITY_MAX = 8'd63;
    // ceil(2^22 / 63): x * RECIP_63 >> 22 equals x / 63 for any 16-bit x
    localparam logic [16:0] RECIP_63 = 17'd66577;

    localparam logic ACT_SPAN  = 1'b0;
    localparam logic ACT_BLEND = 1'b1;

    typedef struct packed {
        logic load;       // capture input beat
        logic map_step;   // mark one color, advance pointer
        logic rd_dst;     // read span of dest color
        logic rd_src;     // read span of src color
        logic div_start;  // start divider
        logic sel_q2;     // 0: dest intensity, 1: src intensity
        logic sel_fin;    // final scaling into the dest span
        logic take_q;     // latch divider result
        logic calc_avg;   // form average and final product
        logic scale;      // multiply product by 1/63
        logic out_load;   // load output register
    } pgb_cmd_t;

    typedef struct packed {
        logic is_blend;
        logic span_ok;
        logic map_last;
        logic map_any;
        logic div_done;
        logic out_busy;
    } pgb_sts_t;

endpackage

[hw/rtl/palette_gradient_blend_core.sv]
// Palette gradient blender, one beat in flight at a time. A span write holds
// the core while it marks each color from start through end (up to 256; none
// when end is below start) and returns nothing. A blend holds it mostly for
// two passes of a bit-serial divider, one for each of the two intensities. The
// result sits in an output register, so the next beat is accepted while it
// waits; a blend whose result is ready while the previous one is still stalled
// waits for it. Depends on pgb_pkg, pgb_ctrl, pgb_dp.
module palette_gradient_blend_core #(
    parameter int SPAN_COUNT = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       action,
    input  logic [4:0] span_number,
    input  logic [7:0] span_start,
    input  logic [7:0] span_end,
    input  logic       span_inverted,
    input  logic [7:0] dest_color,
    input  logic [7:0] src_color,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] blended_color
);
    pgb_pkg::pgb_cmd_t cmd;
    pgb_pkg::pgb_sts_t sts;

    pgb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pgb_dp #(.SPAN_COUNT(SPAN_COUNT)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .action        (action),
        .span_number   (span_number),
        .span_start    (span_start),
        .span_end      (span_end),
        .span_inverted (span_inverted),
        .dest_color    (dest_color),
        .src_color     (src_color),
        .blended_color (blended_color),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );
endmodule

[hw/rtl/pgb_div.sv]
// pgb_div: 16/8 restoring divider, one quotient bit per cycle.
// Depends on nothing; used by pgb_dp.
module pgb_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [7:0]  divisor,
    output logic [15:0] quotient,
    output logic        done
);
    logic [15:0] q_reg, q_next;
    logic [8:0]  r_reg, r_next;
    logic [7:0]  d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [8:0]  trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[7:0], q_reg[15]} - {1'b0, d_reg};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[8])
            begin
                r_next = trial;
                q_next = {q_reg[14:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[7:0], q_reg[15]};
                q_next = {q_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quotient = q_reg;
    assign done     = !busy_reg;
endmodule

[hw/rtl/pgb_dp.sv]
// pgb_dp: span tables, color map, divider and output register.
// Depends on pgb_pkg and pgb_div.
module pgb_dp #(
    parameter int SPAN_COUNT = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pgb_pkg::pgb_cmd_t cmd,
    output pgb_pkg::pgb_sts_t sts,
    input  logic              action,
    input  logic [4:0]        span_number,
    input  logic [7:0]        span_start,
    input  logic [7:0]        span_end,
    input  logic              span_inverted,
    input  logic [7:0]        dest_color,
    input  logic [7:0]        src_color,
    output logic [7:0]        blended_color,
    output logic              out_valid,
    input  logic              out_ready
);
    localparam int SW = (SPAN_COUNT > 1) ? $clog2(SPAN_COUNT) : 1;

    logic [7:0]  start_reg [SPAN_COUNT];
    logic [7:0]  len_reg   [SPAN_COUNT];
    logic [SPAN_COUNT-1:0] inv_reg;
    logic [4:0]  cmap [256];
    logic [255:0] mvalid_reg;

    logic        act_reg;
    logic [4:0]  num_reg;
    logic [7:0]  st_reg, en_reg, dst_reg, src_reg;
    logic [7:0]  ptr_reg;
    logic [4:0]  rd_reg;
    logic [4:0]  sd_reg;
    logic        rd_v_reg;
    logic [7:0]  qd_reg, qs_reg;
    logic [7:0]  lenq_reg;
    logic        invq_reg;
    logic [15:0] prod_reg;
    logic [7:0]  fin_reg;
    logic [7:0]  out_reg;
    logic        ov_reg;

    logic [4:0]  sd_eff, s_cur;
    logic [7:0]  c_cur, t, len_cur;
    logic [15:0] dvd;
    logic [7:0]  dvs;
    logic [15:0] quo;
    logic        div_done_w;
    logic [7:0]  qraw, qfix, avg, avgf;
    logic [8:0]  sum;
    logic [32:0] recip;

    function automatic logic [SW-1:0] sidx(input logic [4:0] s);
        sidx = SW'(s);
    endfunction

    function automatic logic [4:0] span_chk(input logic [4:0] s);
        span_chk = (32'(s) < SPAN_COUNT) ? s : 5'd0;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg    <= action;
            num_reg    <= span_number;
            st_reg     <= span_start;
            en_reg     <= span_end;
            dst_reg    <= dest_color;
            src_reg    <= src_color;
            ptr_reg    <= span_start;
        end
        else if (cmd.map_step)
        begin
            ptr_reg <= ptr_reg + 8'd1;
        end
        if (cmd.map_step && (en_reg >= st_reg))
        begin
            cmap[ptr_reg] <= num_reg;
        end
        if (cmd.rd_dst)
        begin
            rd_reg <= cmap[dst_reg];
        end
        if (cmd.rd_src)
        begin
            rd_reg <= cmap[src_reg];
        end
    end

    // map validity and span tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= '0;
            inv_reg    <= '0;
            rd_v_reg   <= 1'b0;
            for (int i = 0; i < SPAN_COUNT; i++)
            begin
                start_reg[i] <= '0;
                len_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.map_step && (en_reg >= st_reg))
            begin
                mvalid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.rd_dst)
            begin
                rd_v_reg <= mvalid_reg[dst_reg];
            end
            if (cmd.rd_src)
            begin
                rd_v_reg <= mvalid_reg[src_reg];
            end
            if (cmd.load && action == pgb_pkg::ACT_SPAN && 32'(span_number) < SPAN_COUNT)
            begin
                start_reg[SW'(span_number)] <= span_start;
                len_reg[SW'(span_number)]   <= (span_end >= span_start) ?
                    span_end - span_start : span_start - span_end;
                inv_reg[SW'(span_number)]   <= span_inverted;
            end
        end
    end

    // dest span is kept for the final scaling
    always_ff @(posedge clk)
    begin
        if (cmd.div_start && !cmd.sel_q2)
        begin
            sd_reg <= sd_eff;
        end
    end

    assign sd_eff = span_chk(rd_v_reg ? rd_reg : 5'd0);
    assign s_cur  = cmd.sel_fin ? sd_reg : sd_eff;
    assign c_cur  = cmd.sel_q2 ? src_reg : dst_reg;
    assign len_cur = len_reg[sidx(s_cur)];
    assign t      = c_cur - start_reg[sidx(s_cur)];
    assign dvd    = 16'(t) * 16'(pgb_pkg::INTENSITY_MAX);
    assign dvs    = len_cur;

    always_comb
    begin
        sum   = {1'b0, qd_reg} + {1'b0, qs_reg};
        avg   = sum[8:1];
        avgf  = inv_reg[sidx(sd_reg)] ? pgb_pkg::INTENSITY_MAX - avg : avg;
        recip = 33'(prod_reg) * 33'(pgb_pkg::RECIP_63);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            lenq_reg <= dvs;
            invq_reg <= inv_reg[sidx(s_cur)];
        end
    end

    pgb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .quotient (quo),
        .done     (div_done_w)
    );

    assign qraw = (lenq_reg != 8'd0) ? quo[7:0] : 8'd0;
    assign qfix = invq_reg ? pgb_pkg::INTENSITY_MAX - qraw : qraw;

    always_ff @(posedge clk)
    begin
        if (cmd.take_q && !cmd.sel_q2 && !cmd.sel_fin)
        begin
            qd_reg <= qfix;
        end
        if (cmd.take_q && cmd.sel_q2)
        begin
            qs_reg <= qfix;
        end
        if (cmd.calc_avg)
        begin
            prod_reg <= 16'(avgf) * 16'(len_reg[sidx(sd_reg)]);
        end
        if (cmd.scale)
        begin
            fin_reg <= recip[29:22];
        end
        if (cmd.out_load)
        begin
            out_reg <= start_reg[sidx(sd_reg)] + fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    assign blended_color = out_reg;
    assign out_valid     = ov_reg;

    always_comb
    begin
        sts.is_blend = act_reg;
        sts.span_ok  = 32'(num_reg) < SPAN_COUNT;
        sts.map_last = (ptr_reg == en_reg);
        sts.map_any  = (en_reg >= st_reg);
        sts.div_done = div_done_w;
        sts.out_busy = ov_reg && !out_ready;
    end
endmodule

[hw/rtl/pgb_ctrl.sv]
// pgb_ctrl: sequencer for span writes and blends.
// Depends on pgb_pkg.
module pgb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output pgb_pkg::pgb_cmd_t cmd,
    input  pgb_pkg::pgb_sts_t sts
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_MAP   = 4'd2;
    localparam logic [3:0] S_RDD   = 4'd3;
    localparam logic [3:0] S_DIVD  = 4'd4;
    localparam logic [3:0] S_WD    = 4'd5;
    localparam logic [3:0] S_RDS   = 4'd6;
    localparam logic [3:0] S_DIVS  = 4'd7;
    localparam logic [3:0] S_WS    = 4'd8;
    localparam logic [3:0] S_DIVF  = 4'd9;
    localparam logic [3:0] S_WF    = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (sts.is_blend)
                begin
                    state_next = S_RDD;
                end
                else if (sts.span_ok && sts.map_any)
                begin
                    state_next = S_MAP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_MAP:
            begin
                cmd.map_step = 1'b1;
                if (sts.map_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_RDD:
            begin
                cmd.rd_dst = 1'b1;
                state_next = S_DIVD;
            end
            S_DIVD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WD;
            end
            S_WD:
            begin
                if (sts.div_done)
                begin
                    cmd.take_q = 1'b1;
                    state_next = S_RDS;
                end
            end
            S_RDS:
            begin
                cmd.rd_src = 1'b1;
                state_next = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.sel_q2    = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = S_WS;
            end
            S_WS:
            begin
                cmd.sel_q2 = 1'b1;
                if (sts.div_done)
                begin
                    cmd.take_q = 1'b1;
                    state_next = S_DIVF;
                end
            end
            S_DIVF:
            begin
                cmd.sel_fin  = 1'b1;
                cmd.calc_avg = 1'b1;
                state_next   = S_WF;
            end
            S_WF:
            begin
                cmd.sel_fin = 1'b1;
                cmd.scale   = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                cmd.sel_fin = 1'b1;
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

[hw/rtl/pgb_checker.sv]
// pgb_checker: port-level properties of palette_gradient_blend_core.
// Bound to the top level below; sees its ports only.
module pgb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       action,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] blended_color
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blended_color))
        else $error("result dropped or changed while stalled");

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat accepted while busy");

    a_span_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !action && !out_valid |=> !out_valid)
        else $error("span write produced a result");

    a_blend_slow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && action |=> ##1 !in_ready)
        else $error("blend finished too early");
endmodule

bind palette_gradient_blend_core pgb_checker u_pgb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .blended_color (blended_color)
);

[tb/tb.sv]
// Testbench for palette_gradient_blend_core: directed and random span writes and blends,
// with an in-bench predictor of the span tables and a queue of expected blend colors.
// Depends on pgb_pkg and the core RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       action;
        logic [4:0] span_number;
        logic [7:0] span_start;
        logic [7:0] span_end;
        logic       span_inverted;
        logic [7:0] dest_color;
        logic [7:0] src_color;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       action = 1'b0;
    logic [4:0] span_number = '0;
    logic [7:0] span_start = '0;
    logic [7:0] span_end = '0;
    logic       span_inverted = 1'b0;
    logic [7:0] dest_color = '0;
    logic [7:0] src_color = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] blended_color;

    palette_gradient_blend_core u_top (.*);

    beat_t      pending_beats[$];
    logic [7:0] expected_colors[$];
    logic [7:0] span_base[32];
    logic [7:0] span_len[32];
    logic       span_inv[32];
    logic [4:0] color_span[256];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    bit         hold_send = 1'b0;
    int         error_count = 0;

    function automatic logic [7:0] color_level(logic [7:0] c);
        logic [4:0]  s;
        logic [7:0]  t;
        logic [15:0] q;
        s = color_span[c];
        t = c - span_base[s];
        q = (span_len[s] != 0) ? (16'(t) * 16'd63) / 16'(span_len[s]) : 16'd0;
        if (span_inv[s])
            q = 16'(pgb_pkg::INTENSITY_MAX - q[7:0]);
        return q[7:0];
    endfunction

    task automatic predict_beat(beat_t b);
        logic [4:0]  s;
        logic [8:0]  sum;
        logic [7:0]  m;
        logic [15:0] p;
        if (b.action == pgb_pkg::ACT_SPAN)
        begin
            span_base[b.span_number] = b.span_start;
            span_len[b.span_number] = (b.span_end >= b.span_start) ?
                b.span_end - b.span_start : b.span_start - b.span_end;
            span_inv[b.span_number] = b.span_inverted;
            for (int c = b.span_start; c <= b.span_end; c++)
                color_span[c] = b.span_number;
        end
        else
        begin
            s = color_span[b.dest_color];
            sum = 9'(color_level(b.dest_color)) + 9'(color_level(b.src_color));
            m = sum[8:1];
            if (span_inv[s])
                m = pgb_pkg::INTENSITY_MAX - m;
            p = (16'(m) * 16'(span_len[s])) / 16'd63;
            expected_colors.push_back(span_base[s] + p[7:0]);
        end
    endtask

    function automatic beat_t rand_beat(bit blend);
        beat_t b;
        b = beat_t'(39'({$urandom, $urandom}));
        b.action = blend ? pgb_pkg::ACT_BLEND : pgb_pkg::ACT_SPAN;
        if (!blend && $urandom_range(0, 3) != 0)
        begin
            b.span_end = b.span_start + 8'($urandom_range(0, 24));
            if (b.span_end < b.span_start)
                b.span_end = 8'hff;
        end
        return b;
    endfunction

    function automatic beat_t make_span(int n, int st, int en, bit inv);
        beat_t b;
        b = beat_t'(39'({$urandom, $urandom}));
        b.action = pgb_pkg::ACT_SPAN;
        b.span_number = 5'(n);
        b.span_start = 8'(st);
        b.span_end = 8'(en);
        b.span_inverted = inv;
        return b;
    endfunction

    function automatic beat_t make_blend(int d, int s);
        beat_t b;
        b = beat_t'(39'({$urandom, $urandom}));
        b.action = pgb_pkg::ACT_BLEND;
        b.dest_color = 8'(d);
        b.src_color = 8'(s);
        return b;
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            predict_beat(pending_beats.pop_front());
        end
        if (!(in_valid && !in_ready))
        begin
            if (rst_n && !hold_send && pending_beats.size() != 0
                && $urandom_range(0, 99) >= send_idle_pct
                && !(in_valid && in_ready && pending_beats.size() == 0))
            begin
                in_valid      <= 1'b1;
                action        <= pending_beats[0].action;
                span_number   <= pending_beats[0].span_number;
                span_start    <= pending_beats[0].span_start;
                span_end      <= pending_beats[0].span_end;
                span_inverted <= pending_beats[0].span_inverted;
                dest_color    <= pending_beats[0].dest_color;
                src_color     <= pending_beats[0].src_color;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_colors.size() == 0)
            begin
                $error("blended_color: no beat expected, actual %0d", blended_color);
                error_count++;
            end
            else
            begin
                if (blended_color !== expected_colors[0])
                begin
                    $error("blended_color: expected %0d actual %0d",
                           expected_colors[0], blended_color);
                    error_count++;
                end
                void'(expected_colors.pop_front());
            end
        end
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    initial
    begin
        int idle_tbl[4];
        int stall_tbl[4];
        idle_tbl = '{0, 59, 0, 6};
        stall_tbl = '{0, 0, 59, 6};
        for (int i = 0; i < 32; i++)
        begin
            span_base[i] = '0;
            span_len[i] = '0;
            span_inv[i] = 1'b0;
        end
        for (int i = 0; i < 256; i++)
            color_span[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        // directed: zero-length default span, a full span, inverse, reversed, stale marks
        pending_beats.push_back(make_blend(0, 255));
        pending_beats.push_back(make_blend(255, 0));
        pending_beats.push_back(make_span(0, 0, 255, 1'b0));
        pending_beats.push_back(make_blend(0, 255));
        pending_beats.push_back(make_blend(255, 255));
        pending_beats.push_back(make_blend(128, 7));
        pending_beats.push_back(make_span(31, 16, 31, 1'b1));
        pending_beats.push_back(make_blend(16, 31));
        pending_beats.push_back(make_blend(31, 200));
        pending_beats.push_back(make_span(5, 200, 100, 1'b1));
        pending_beats.push_back(make_blend(150, 20));
        pending_beats.push_back(make_span(7, 64, 64, 1'b1));
        pending_beats.push_back(make_blend(64, 64));
        pending_beats.push_back(make_blend(3, 64));
        pending_beats.push_back(make_span(31, 250, 255, 1'b0));
        pending_beats.push_back(make_blend(20, 252));
        pending_beats.push_back(make_span(7, 0, 0, 1'b0));
        pending_beats.push_back(make_blend(64, 0));
        pending_beats.push_back(make_blend(255, 170));
        drain();
        hold_send = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_tbl[p];
            recv_stall_pct = stall_tbl[p];
            hold_send = 1'b0;
            for (int i = 0; i < 210; i++)
                pending_beats.push_back(rand_beat($urandom_range(0, 99) < 75));
            drain();
        end
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
